[sv/stk_pkg.sv]
// Shared types and constants of the serial frame receiver.
`default_nettype none
package stk_pkg;

  localparam logic [7:0]  START_BYTE   = 8'h1B;
  localparam logic [7:0]  TOKEN_BYTE   = 8'h0E;
  localparam logic [7:0]  CR_BYTE      = 8'h0D;
  localparam logic [7:0]  LF_BYTE      = 8'h0A;
  localparam logic [15:0] MAX_BODY_RST = 16'd280;
  localparam logic [2:0]  LF_ONLY_CNT  = 3'd2;
  localparam logic [2:0]  CRLF_CNT     = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SEQ    = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_TOKEN  = 3'd4,
    PH_BODY   = 3'd5,
    PH_CKSUM  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_BODY      = 3'd0,
    EV_GOOD      = 3'd1,
    EV_CKSUM_ERR = 3'd2,
    EV_TERMINAL  = 3'd3,
    EV_ABORT     = 3'd4
  } event_e;

  typedef struct packed {
    event_e      kind;
    logic [7:0]  data;
    logic [15:0] idx;
    logic        last;
    logic [7:0]  seq;
    logic [15:0] len;
    logic        crlf;
  } event_t;

endpackage
`default_nettype wire

[sv/stk_if.sv]
// Valid/ready channels for received bytes and frame events.
`default_nettype none
interface stk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stk_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic        last_body_byte;
  logic [7:0]  sequence_number;
  logic [15:0] frame_length;
  logic        crlf_line_ends;

  modport source (output valid, output event_kind, output data_byte, output byte_index,
                  output last_body_byte, output sequence_number, output frame_length,
                  output crlf_line_ends, input ready);
  modport sink   (input valid, input event_kind, input data_byte, input byte_index,
                  input last_body_byte, input sequence_number, input frame_length,
                  input crlf_line_ends, output ready);
endinterface
`default_nettype wire

[sv/stk_in_reg.sv]
// Input register stage holding one received byte.
`default_nettype none
module stk_in_reg (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stk_byte_if.sink    rx_i,
  input  wire logic   advance_i,
  output logic [7:0]  byte_o,
  output logic        valid_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign rx_i.ready = !valid_q || advance_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

[sv/stk_parser.sv]
// Frame parse state and per-byte event logic.
`default_nettype none
module stk_parser
  import stk_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] max_len_i,
  output event_t           res_o,
  output logic             res_valid_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [2:0]  lec_q, lec_d;
  logic        prev_cr_q, prev_cr_d;
  logic        crlf_q, crlf_d;
  logic [15:0] cnt_inc;
  logic [2:0]  lec_inc;
  logic        crlf_new;

  assign cnt_inc  = cnt_q + 16'd1;
  assign lec_inc  = lec_q + 3'd1;
  assign crlf_new = crlf_q || (byte_i == LF_BYTE && prev_cr_q);

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    xor_d     = xor_q;
    seq_d     = seq_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    lec_d     = lec_q;
    prev_cr_d = prev_cr_q;
    crlf_d    = crlf_q;
    unique case (phase_q)
      PH_SEQ: begin
        seq_d   = byte_i;
        xor_d   = xor_q ^ byte_i;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        xor_d   = xor_q ^ byte_i;
        len_d   = {byte_i, 8'h00};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        xor_d   = xor_q ^ byte_i;
        len_d   = {len_q[15:8], byte_i};
        phase_d = PH_TOKEN;
      end
      PH_TOKEN: begin
        xor_d = xor_q ^ byte_i;
        if (byte_i == TOKEN_BYTE) begin
          phase_d = PH_BODY;
          cnt_d   = 16'd0;
          lec_d   = 3'd0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_BODY: begin
        if (cnt_q < len_q && cnt_q < max_len_i) begin
          xor_d = xor_q ^ byte_i;
          cnt_d = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = PH_CKSUM;
          end
        end else begin
          phase_d   = PH_IDLE;
          seq_d     = 8'd0;
          len_d     = 16'd0;
          cnt_d     = 16'd0;
          lec_d     = 3'd0;
          prev_cr_d = 1'b0;
        end
      end
      PH_CKSUM: begin
        phase_d   = PH_IDLE;
        seq_d     = 8'd0;
        len_d     = 16'd0;
        cnt_d     = 16'd0;
        lec_d     = 3'd0;
        prev_cr_d = 1'b0;
      end
      default: begin
        phase_d = PH_IDLE;
        if (byte_i == START_BYTE) begin
          phase_d = PH_SEQ;
          xor_d   = START_BYTE;
        end else if (byte_i == CR_BYTE || byte_i == LF_BYTE) begin
          crlf_d    = crlf_new;
          prev_cr_d = (byte_i == CR_BYTE);
          lec_d     = lec_inc;
          if (lec_inc >= (crlf_new ? CRLF_CNT : LF_ONLY_CNT)) begin
            lec_d = 3'd0;
          end
        end else begin
          seq_d     = 8'd0;
          len_d     = 16'd0;
          cnt_d     = 16'd0;
          lec_d     = 3'd0;
          prev_cr_d = 1'b0;
        end
      end
    endcase
  end

  // Result for the byte at hand.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = EV_BODY;
    unique case (phase_q)
      PH_SEQ, PH_LEN_HI, PH_LEN_LO, PH_TOKEN: begin
        res_valid_o = 1'b0;
      end
      PH_BODY: begin
        res_valid_o = 1'b1;
        res_o.seq   = seq_q;
        res_o.len   = len_q;
        res_o.idx   = cnt_q;
        if (cnt_q < len_q && cnt_q < max_len_i) begin
          res_o.kind = EV_BODY;
          res_o.data = byte_i;
          res_o.last = (cnt_inc == len_q);
        end else begin
          res_o.kind = EV_ABORT;
        end
      end
      PH_CKSUM: begin
        res_valid_o = 1'b1;
        res_o.kind  = (byte_i == xor_q) ? EV_GOOD : EV_CKSUM_ERR;
        res_o.seq   = seq_q;
        res_o.len   = len_q;
        res_o.idx   = cnt_q;
      end
      default: begin
        if (byte_i != START_BYTE && (byte_i == CR_BYTE || byte_i == LF_BYTE) &&
            lec_inc >= (crlf_new ? CRLF_CNT : LF_ONLY_CNT)) begin
          res_valid_o = 1'b1;
          res_o.kind  = EV_TERMINAL;
          res_o.crlf  = crlf_new;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      xor_q     <= 8'd0;
      seq_q     <= 8'd0;
      len_q     <= 16'd0;
      cnt_q     <= 16'd0;
      lec_q     <= 3'd0;
      prev_cr_q <= 1'b0;
      crlf_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      xor_q     <= xor_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      lec_q     <= lec_d;
      prev_cr_q <= prev_cr_d;
      crlf_q    <= crlf_d;
    end
  end

endmodule
`default_nettype wire

[sv/stk500v2_frame_receiver_core.sv]
// Path: input register, then combinational parse, then result register to the output.
// Throughput: one byte per cycle while no event waits on a stalled output; an input
// register and a result register decouple the two channels, and a byte that causes
// no event never waits on the output. Reset: asynchronous, active low; parser returns
// to idle, limit register to 280, both pipeline registers empty.
`default_nettype none
module stk500v2_frame_receiver_core
  import stk_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  stk_byte_if.sink         rx_i,
  stk_event_if.source      ev_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [15:0] max_len_q;
  logic [7:0]  in_byte;
  logic        in_valid;
  logic        step;
  logic        out_free;
  event_t      res;
  logic        res_valid;
  event_t      res_q;
  logic        out_valid_q, out_valid_d;
  logic        load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_BODY_RST;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  stk_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (step),
    .byte_o    (in_byte),
    .valid_o   (in_valid)
  );

  stk_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .max_len_i   (max_len_q),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  // Advance a byte unless its event would overwrite one still waiting.
  assign out_free = !out_valid_q || ev_o.ready;
  assign step     = in_valid && (!res_valid || out_free);
  assign load     = step && res_valid;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (ev_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign ev_o.valid           = out_valid_q;
  assign ev_o.event_kind      = res_q.kind;
  assign ev_o.data_byte       = res_q.data;
  assign ev_o.byte_index      = res_q.idx;
  assign ev_o.last_body_byte  = res_q.last;
  assign ev_o.sequence_number = res_q.seq;
  assign ev_o.frame_length    = res_q.len;
  assign ev_o.crlf_line_ends  = res_q.crlf;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("event loaded but output not valid");

  a_body_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == EV_BODY) |-> (res_q.idx < res_q.len))
    else $error("body byte index beyond declared length");

  a_non_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind != EV_BODY) |-> (res_q.data == 8'd0 && !res_q.last))
    else $error("non-body event carries body data");

  a_terminal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == EV_TERMINAL) |->
      (res_q.seq == 8'd0 && res_q.len == 16'd0 && res_q.idx == 16'd0))
    else $error("terminal request carries frame fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ev_o.ready) |-> !load)
    else $error("pending event overwritten");

endmodule
`default_nettype wire
